// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files of the servo ramp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while the synchronous reset is held.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that stays live through reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dsro_pkg.sv -----
// Package: constants, register codes and widths of the dual servo ramp block.
`timescale 1ns / 1ps

package dsro_pkg;

  localparam int RAMP_STEPS_DEFAULT = 128;

  // Ticks of overdrive after each movement of the ramp counter.
  localparam int OVERDRIVE_TICKS = 32;
  localparam int OD_W = 8;
  localparam logic [OD_W-1:0] OD_RELOAD = OD_W'(OVERDRIVE_TICKS);
  localparam logic [OD_W-1:0] OD_AFTER_RELOAD = OD_W'(OVERDRIVE_TICKS - 1);

  localparam int COMPARE_W = 16;
  localparam int OFFSET_W = 14;
  localparam int POS_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_SERVOS = 2;

  // Base and span carry a 16 bit point plus two 14 bit offsets, signed.
  localparam int SPAN_W = 18;
  localparam int RES_W = SPAN_W + 1;

  localparam logic [COMPARE_W-1:0] COMPARE_MAX = '1;
  localparam logic [COMPARE_W-1:0] POINT_RESET = 16'd480;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_A_CLOSED       = 3'd0,
    REG_A_OPEN         = 3'd1,
    REG_B_CLOSED       = 3'd2,
    REG_B_OPEN         = 3'd3,
    REG_A_CLOSED_EXTRA = 3'd4,
    REG_A_OPEN_EXTRA   = 3'd5,
    REG_B_CLOSED_EXTRA = 3'd6,
    REG_B_OPEN_EXTRA   = 3'd7
  } cfg_reg_t;

endpackage

// ----- sv/dual_servo_ramp_with_overdrive_unit.sv -----
// Top level: dual servo ramp with overdrive, five register stages.
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid / in_stall with open_request. Each transaction is
//   one control tick; the ramp counter steps one count toward RAMP_STEPS
//   (open) or zero (closed) and any step reloads the overdrive countdown.
//   Output channel: out_valid / out_stall with both servo compare values,
//   the ramp position after the tick and the overdrive flag. One result per
//   tick, in order.
//   Configuration: cfg_write, cfg_index, cfg_data write one of eight
//   registers; write only while no tick is in flight.
//   Path: an accepted tick passes the stages in order (offsets, multiply,
//   reciprocal multiply, correction, saturation) into the output register.
//   Throughput: one tick per cycle; every stage loads each cycle unless the
//   stalled output backs the pipeline up to the input.
//   Stall: a stalled result holds in the output register; earlier stages
//   keep filling their empty slots, and in_stall rises only once every
//   stage is occupied.
//   Reset (rst, synchronous): ramp counter and countdown go to zero, the
//   registers to their reset values, and the pipeline empties.

`include "assert_macros.svh"

module dual_servo_ramp_with_overdrive_unit
  import dsro_pkg::*;
#(
  parameter int RAMP_STEPS = RAMP_STEPS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   open_request,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COMPARE_W-1:0]   servo_a_compare,
  output logic [COMPARE_W-1:0]   servo_b_compare,
  output logic [POS_W-1:0]       ramp_position,
  output logic                   overdrive_active,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(RAMP_STEPS + 1);
  localparam int MAG_W = SPAN_W - 1 + CNT_W;
  localparam int PROD_W = MAG_W + 2;
  localparam int Q_W = SPAN_W - 1;
  localparam int RP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] RAMP_MAX = CNT_W'(RAMP_STEPS);
  localparam logic [MAG_W-1:0] RAMP_DIV = MAG_W'(RAMP_STEPS);
  // floor(2^MAG_W / RAMP_STEPS): the estimate is exact or one short.
  localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'((64'd1 << MAG_W) / RAMP_STEPS);

  // Configuration registers, one entry per servo
  logic [COMPARE_W-1:0]       closed_pt [NUM_SERVOS];
  logic [COMPARE_W-1:0]       open_pt   [NUM_SERVOS];
  logic signed [OFFSET_W-1:0] closed_x  [NUM_SERVOS];
  logic signed [OFFSET_W-1:0] open_x    [NUM_SERVOS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        closed_pt[i] <= POINT_RESET;
        open_pt[i]   <= POINT_RESET;
        closed_x[i]  <= OFFSET_RESET;
        open_x[i]    <= OFFSET_RESET;
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_A_CLOSED:       closed_pt[0] <= cfg_data;
        REG_A_OPEN:         open_pt[0]   <= cfg_data;
        REG_B_CLOSED:       closed_pt[1] <= cfg_data;
        REG_B_OPEN:         open_pt[1]   <= cfg_data;
        REG_A_CLOSED_EXTRA: closed_x[0]  <= cfg_data[OFFSET_W-1:0];
        REG_A_OPEN_EXTRA:   open_x[0]    <= cfg_data[OFFSET_W-1:0];
        REG_B_CLOSED_EXTRA: closed_x[1]  <= cfg_data[OFFSET_W-1:0];
        REG_B_OPEN_EXTRA:   open_x[1]    <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when it empties
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic ld1, ld2, ld3, ld4, ld_out;
  logic accept;

  assign ld_out   = !out_valid || !out_stall;
  assign ld4      = !s4_valid || ld_out;
  assign ld3      = !s3_valid || ld4;
  assign ld2      = !s2_valid || ld3;
  assign ld1      = !s1_valid || ld2;
  assign in_stall = !ld1;
  assign accept   = in_valid && ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid  <= in_valid;
      if (ld2)    s2_valid  <= s1_valid;
      if (ld3)    s3_valid  <= s2_valid;
      if (ld4)    s4_valid  <= s3_valid;
      if (ld_out) out_valid <= s4_valid;
    end
  end

  // Ramp counter and overdrive countdown
  logic [CNT_W-1:0] ramp_counter, ramp_counter_next;
  logic [OD_W-1:0]  countdown, countdown_next, countdown_loaded;
  logic             moved, od;

  always_comb begin
    ramp_counter_next = ramp_counter;
    moved = 1'b0;
    if (open_request && (ramp_counter < RAMP_MAX)) begin
      ramp_counter_next = ramp_counter + CNT_W'(1);
      moved = 1'b1;
    end else if (!open_request && (ramp_counter != '0)) begin
      ramp_counter_next = ramp_counter - CNT_W'(1);
      moved = 1'b1;
    end
    countdown_loaded = moved ? OD_RELOAD : countdown;
    od = (countdown_loaded != '0);
    countdown_next = od ? (countdown_loaded - OD_W'(1)) : countdown_loaded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_counter <= '0;
      countdown    <= '0;
    end else if (accept) begin
      ramp_counter <= ramp_counter_next;
      countdown    <= countdown_next;
    end
  end

  // Stage 1: closed point and span, widened by the offsets under overdrive
  logic signed [SPAN_W-1:0] base_next [NUM_SERVOS];
  logic signed [SPAN_W-1:0] span_next [NUM_SERVOS];
  logic signed [SPAN_W-1:0] s1_base   [NUM_SERVOS];
  logic signed [SPAN_W-1:0] s1_span   [NUM_SERVOS];
  logic [CNT_W-1:0]         s1_ramp;
  logic                     s1_od;

  always_comb begin
    for (int i = 0; i < NUM_SERVOS; i++) begin
      base_next[i] = SPAN_W'(closed_pt[i]) + (od ? SPAN_W'(closed_x[i]) : SPAN_W'(0));
      span_next[i] = SPAN_W'(open_pt[i]) - SPAN_W'(closed_pt[i])
                     + (od ? (SPAN_W'(open_x[i]) - SPAN_W'(closed_x[i])) : SPAN_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_base <= base_next;
      s1_span <= span_next;
      s1_ramp <= ramp_counter_next;
      s1_od   <= od;
    end
  end

  // Stage 2: span times ramp count
  logic signed [PROD_W-1:0] s2_prod [NUM_SERVOS];
  logic signed [SPAN_W-1:0] s2_base [NUM_SERVOS];
  logic [CNT_W-1:0]         s2_ramp;
  logic                     s2_od;
  logic signed [PROD_W-1:0] ramp_s;

  assign ramp_s = PROD_W'($signed({1'b0, s1_ramp}));

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        s2_prod[i] <= PROD_W'(s1_span[i]) * ramp_s;
      end
      s2_base <= s1_base;
      s2_ramp <= s1_ramp;
      s2_od   <= s1_od;
    end
  end

  // Stage 3: magnitude and reciprocal estimate of the quotient
  logic [MAG_W-1:0]         mag_next [NUM_SERVOS];
  logic [2*MAG_W:0]         est_full [NUM_SERVOS];
  logic [MAG_W-1:0]         s3_mag   [NUM_SERVOS];
  logic [Q_W-1:0]           s3_qe    [NUM_SERVOS];
  logic                     s3_neg   [NUM_SERVOS];
  logic signed [SPAN_W-1:0] s3_base  [NUM_SERVOS];
  logic [CNT_W-1:0]         s3_ramp;
  logic                     s3_od;

  always_comb begin
    for (int i = 0; i < NUM_SERVOS; i++) begin
      mag_next[i] = s2_prod[i][PROD_W-1] ? MAG_W'(-s2_prod[i]) : MAG_W'(s2_prod[i]);
      est_full[i] = (2*MAG_W + 1)'(mag_next[i]) * (2*MAG_W + 1)'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        s3_mag[i] <= mag_next[i];
        s3_qe[i]  <= est_full[i][MAG_W +: Q_W];
        s3_neg[i] <= s2_prod[i][PROD_W-1];
      end
      s3_base <= s2_base;
      s3_ramp <= s2_ramp;
      s3_od   <= s2_od;
    end
  end

  // Stage 4: fix the estimate by one and restore the sign (truncate to zero)
  logic [MAG_W-1:0]         rem      [NUM_SERVOS];
  logic [Q_W-1:0]           quot     [NUM_SERVOS];
  logic signed [RES_W-1:0]  s4_quot  [NUM_SERVOS];
  logic signed [SPAN_W-1:0] s4_base  [NUM_SERVOS];
  logic [CNT_W-1:0]         s4_ramp;
  logic                     s4_od;

  always_comb begin
    for (int i = 0; i < NUM_SERVOS; i++) begin
      rem[i]  = s3_mag[i] - (MAG_W'(s3_qe[i]) * RAMP_DIV);
      quot[i] = s3_qe[i] + Q_W'(rem[i] >= RAMP_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        s4_quot[i] <= s3_neg[i] ? -RES_W'($signed({1'b0, quot[i]}))
                                :  RES_W'($signed({1'b0, quot[i]}));
      end
      s4_base <= s3_base;
      s4_ramp <= s3_ramp;
      s4_od   <= s3_od;
    end
  end

  // Output stage: add the base and saturate
  logic signed [RES_W-1:0] sum [NUM_SERVOS];
  logic [COMPARE_W-1:0]    sat [NUM_SERVOS];
  logic [RP_W-1:0]         ramp_ext;

  always_comb begin
    for (int i = 0; i < NUM_SERVOS; i++) begin
      sum[i] = RES_W'(s4_base[i]) + s4_quot[i];
      if (sum[i] < 0) begin
        sat[i] = '0;
      end else if (sum[i] > RES_W'(COMPARE_MAX)) begin
        sat[i] = COMPARE_MAX;
      end else begin
        sat[i] = sum[i][COMPARE_W-1:0];
      end
    end
  end

  assign ramp_ext = RP_W'(s4_ramp);

  always_ff @(posedge clk) begin
    if (ld_out) begin
      servo_a_compare  <= sat[0];
      servo_b_compare  <= sat[1];
      ramp_position    <= ramp_ext[POS_W-1:0];
      overdrive_active <= s4_od;
    end
  end

  `ASSERT_CLK(a_ramp_range, ramp_counter <= RAMP_MAX, "ramp counter beyond full count")
  `ASSERT_CLK(a_ramp_hold, !accept |=> $stable(ramp_counter), "ramp moved without a transaction")
  `ASSERT_CLK(a_od_reload, (accept && moved) |=> (countdown == OD_AFTER_RELOAD),
              "movement did not reload the overdrive countdown")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !s1_valid && ramp_counter == '0),
                 "pipeline or ramp not cleared by reset")

endmodule

// ----- test/servo_ramp_checker.sv -----
// Checker for the servo ramp block: mirrors its registers and state, predicts and compares.
`timescale 1ns / 1ps

module servo_ramp_checker
  import dsro_pkg::*;
#(
  parameter int RAMP_STEPS = RAMP_STEPS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   open_request,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [COMPARE_W-1:0]   servo_a_compare,
  input  logic [COMPARE_W-1:0]   servo_b_compare,
  input  logic [POS_W-1:0]       ramp_position,
  input  logic                   overdrive_active,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     outstanding,
  output int                     results_seen,
  output int                     overdrive_seen
);

  localparam int SERVO_A = 0;
  localparam int SERVO_B = 1;

  typedef struct packed {
    logic [COMPARE_W-1:0] a_compare;
    logic [COMPARE_W-1:0] b_compare;
    logic [POS_W-1:0]     position;
    logic                 overdrive;
  } servo_result_t;

  servo_result_t              compare_q[$];
  logic [COMPARE_W-1:0]       closed_pt [NUM_SERVOS];
  logic [COMPARE_W-1:0]       open_pt [NUM_SERVOS];
  logic signed [OFFSET_W-1:0] closed_x [NUM_SERVOS];
  logic signed [OFFSET_W-1:0] open_x [NUM_SERVOS];
  int                         ramp_count;
  logic [OD_W-1:0]            od_count;

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [COMPARE_W-1:0] servo_compare(input int s, input logic od_on);
    longint base;
    longint span;
    longint val;
    base = longint'(closed_pt[s]);
    span = longint'(open_pt[s]) - longint'(closed_pt[s]);
    if (od_on) begin
      base += longint'(closed_x[s]);
      span += longint'(open_x[s]) - longint'(closed_x[s]);
    end
    // signed division truncates toward zero
    val = base + (span * longint'(ramp_count)) / longint'(RAMP_STEPS);
    if (val < 0) val = 0;
    if (val > longint'(COMPARE_MAX)) val = longint'(COMPARE_MAX);
    return COMPARE_W'(val);
  endfunction

  task automatic advance_ramp(input logic req, output servo_result_t res);
    int   target;
    logic od_on;
    target = req ? RAMP_STEPS : 0;
    // any movement reloads the overdrive countdown
    if (target > ramp_count) begin
      ramp_count++;
      od_count = OD_W'(OVERDRIVE_TICKS);
    end else if (target < ramp_count) begin
      ramp_count--;
      od_count = OD_W'(OVERDRIVE_TICKS);
    end
    od_on = (od_count != '0);
    if (od_on) od_count--;
    if (ramp_count > RAMP_STEPS) ramp_count = RAMP_STEPS;
    res.a_compare = servo_compare(SERVO_A, od_on);
    res.b_compare = servo_compare(SERVO_B, od_on);
    res.position  = POS_W'(ramp_count);
    res.overdrive = od_on;
  endtask

  always @(posedge clk) begin : monitor
    servo_result_t fresh;
    servo_result_t want;
    if (rst) begin
      compare_q.delete();
      for (int s = 0; s < NUM_SERVOS; s++) begin
        closed_pt[s] = POINT_RESET;
        open_pt[s]   = POINT_RESET;
        closed_x[s]  = OFFSET_RESET;
        open_x[s]    = OFFSET_RESET;
      end
      ramp_count = 0;
      od_count = '0;
      errors = 0;
      results_seen = 0;
      overdrive_seen = 0;
    end else begin
      if (cfg_write) begin
        // offset registers drop the data bits above their width
        case (cfg_index)
          REG_A_CLOSED:       closed_pt[SERVO_A] = cfg_data;
          REG_A_OPEN:         open_pt[SERVO_A]   = cfg_data;
          REG_B_CLOSED:       closed_pt[SERVO_B] = cfg_data;
          REG_B_OPEN:         open_pt[SERVO_B]   = cfg_data;
          REG_A_CLOSED_EXTRA: closed_x[SERVO_A]  = cfg_data[OFFSET_W-1:0];
          REG_A_OPEN_EXTRA:   open_x[SERVO_A]    = cfg_data[OFFSET_W-1:0];
          REG_B_CLOSED_EXTRA: closed_x[SERVO_B]  = cfg_data[OFFSET_W-1:0];
          REG_B_OPEN_EXTRA:   open_x[SERVO_B]    = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_ramp(open_request, fresh);
        compare_q.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        if (compare_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with no tick waiting", results_seen));
        end else begin
          want = compare_q.pop_front();
          if (servo_a_compare !== want.a_compare)
            report_error($sformatf("result %0d servo A compare %0d, expected %0d",
                                   results_seen, servo_a_compare, want.a_compare));
          if (servo_b_compare !== want.b_compare)
            report_error($sformatf("result %0d servo B compare %0d, expected %0d",
                                   results_seen, servo_b_compare, want.b_compare));
          if (ramp_position !== want.position)
            report_error($sformatf("result %0d ramp position %0d, expected %0d",
                                   results_seen, ramp_position, want.position));
          if (overdrive_active !== want.overdrive)
            report_error($sformatf("result %0d overdrive flag %b, expected %b",
                                   results_seen, overdrive_active, want.overdrive));
        end
        results_seen++;
        if (overdrive_active === 1'b1) overdrive_seen++;
      end
    end
    outstanding <= compare_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top: drives ticks, register settings and back-pressure into the servo ramp block.
`timescale 1ns / 1ps

module tb_top;
  import dsro_pkg::*;

  localparam int RAMP_STEPS    = RAMP_STEPS_DEFAULT;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_TICKS   = 178;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 open_request = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_write = 1'b0;
  cfg_reg_t             cfg_index = REG_A_CLOSED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [COMPARE_W-1:0] servo_a_compare;
  logic [COMPARE_W-1:0] servo_b_compare;
  logic [POS_W-1:0]     ramp_position;
  logic                 overdrive_active;

  int   errors;
  int   outstanding;
  int   results_seen;
  int   overdrive_seen;
  int   ticks_sent = 0;
  int   settings_count = 0;
  int   stall_left = 0;
  logic sender_gaps = 1'b1;
  logic receiver_stalls = 1'b1;

  dual_servo_ramp_with_overdrive_unit #(.RAMP_STEPS(RAMP_STEPS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .open_request(open_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .servo_a_compare(servo_a_compare), .servo_b_compare(servo_b_compare),
    .ramp_position(ramp_position), .overdrive_active(overdrive_active),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  servo_ramp_checker #(.RAMP_STEPS(RAMP_STEPS)) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .open_request(open_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .servo_a_compare(servo_a_compare), .servo_b_compare(servo_b_compare),
    .ramp_position(ramp_position), .overdrive_active(overdrive_active),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding),
    .results_seen(results_seen), .overdrive_seen(overdrive_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 4);
    if (r < 75) return $urandom_range(5, 40);
    // long enough to cross the whole ramp to an end
    return $urandom_range(130, 220);
  endfunction

  function automatic logic [COMPARE_W-1:0] random_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return COMPARE_MAX;
    return COMPARE_W'($urandom_range(0, 65535));
  endfunction

  function automatic int random_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return -4096;
    if (r < 40) return 4096;
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  // fill the bits above the offset width with noise; the block drops them
  function automatic logic [CFG_DATA_W-1:0] offset_word(input int v);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'(v);
    w[CFG_DATA_W-1:OFFSET_W] = (CFG_DATA_W - OFFSET_W)'($urandom_range(0, 3));
    return w;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_pause();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // returns in the time step of the accepting edge, valid still high
  task automatic send_tick(input logic req);
    int gap;
    gap = sender_gaps ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    open_request <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ticks_sent++;
  endtask

  // drop valid and hold until every result is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // each call is applied at the following edge
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
  endtask

  task automatic program_settings(input logic [COMPARE_W-1:0] a_closed, a_open,
                                  input logic [COMPARE_W-1:0] b_closed, b_open,
                                  input int ax_closed, ax_open, bx_closed, bx_open);
    write_reg(REG_A_CLOSED, a_closed);
    write_reg(REG_A_OPEN, a_open);
    write_reg(REG_B_CLOSED, b_closed);
    write_reg(REG_B_OPEN, b_open);
    write_reg(REG_A_CLOSED_EXTRA, offset_word(ax_closed));
    write_reg(REG_A_OPEN_EXTRA, offset_word(ax_open));
    write_reg(REG_B_CLOSED_EXTRA, offset_word(bx_closed));
    write_reg(REG_B_OPEN_EXTRA, offset_word(bx_open));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  initial begin : stimulus
    int   phase;
    int   in_phase;
    int   run_len;
    logic req;
    logic paused;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: hold closed at zero, open a few steps, close back and hold
    repeat (3) send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    // extreme points and offsets: compares saturate low and high under overdrive
    program_settings('0, COMPARE_MAX, COMPARE_MAX, '0, -4096, 4096, 4096, -4096);
    repeat (4) send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_settings(COMPARE_MAX, '0, '0, COMPARE_MAX, 4096, -4096, -4096, 4096);
        1: program_settings('0, '0, COMPARE_MAX, COMPARE_MAX, -4096, -4096, 4096, 4096);
        default: program_settings(random_point(), random_point(), random_point(),
                                  random_point(), random_offset(), random_offset(),
                                  random_offset(), random_offset());
      endcase
      sender_gaps = (phase % 3 != 2);
      receiver_stalls = (phase % 3 != 1);
      in_phase = 0;
      paused = 1'b0;
      while (in_phase < PHASE_TICKS) begin
        run_len = pick_run();
        if (run_len > PHASE_TICKS - in_phase) run_len = PHASE_TICKS - in_phase;
        req = 1'($urandom_range(0, 1));
        // runs of one request, broken now and then by a stray transaction
        repeat (run_len) send_tick(($urandom_range(0, 99) < 5) ? !req : req);
        in_phase += run_len;
        if (phase % 2 == 1 && !paused && in_phase >= PHASE_TICKS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    $display("%0d ticks sent over %0d register settings after the reset values",
             ticks_sent, settings_count);
    $display("%0d results compared, %0d of them with overdrive applied",
             results_seen, overdrive_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // end the run if no transaction or register write happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_write)
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
